// ----- sv/pfm_pkg.sv -----
`default_nettype none

package pfm_pkg;

  localparam int unsigned TpsW  = 24;
  localparam int unsigned TickW = 32;
  localparam int unsigned FreqW = 32;
  localparam int unsigned FracW = 8;
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam logic [TpsW-1:0]  TpsReset     = 24'd1000000;
  localparam logic [TickW-1:0] TimeoutReset = 32'd500000;
  localparam logic [TickW-1:0] TickSat      = '1;

  localparam logic [CfgIdxW-1:0] CfgTicksPerSecond = 8'd0;
  localparam logic [CfgIdxW-1:0] CfgTimeoutTicks   = 8'd1;

  localparam int unsigned WindowDefault     = 5;
  localparam int unsigned QueueDepthDefault = 4;

  // one classified tick, front to back
  typedef struct packed {
    logic             record;     // edge with a valid period: measure and average
    logic             edge_seen;
    logic             timed_out;
    logic [TickW-1:0] period;
  } pfm_item_t;

endpackage

`default_nettype wire

// ----- sv/pfm_front.sv -----
`default_nettype none

module pfm_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       take_i,
  input  wire logic                       level_i,
  input  wire logic [pfm_pkg::TickW-1:0]  timeout_ticks_i,
  output pfm_pkg::pfm_item_t              item_o
);

  logic                      last_level_q, last_level_d;
  logic                      first_done_q, first_done_d;
  logic [pfm_pkg::TickW-1:0] period_q, period_d;
  logic [pfm_pkg::TickW-1:0] since_q, since_d;
  logic [pfm_pkg::TickW-1:0] period_inc;
  logic [pfm_pkg::TickW-1:0] since_new;
  logic                      rise;

  assign rise       = level_i & ~last_level_q;
  assign period_inc = (period_q == pfm_pkg::TickSat) ? period_q : period_q + 1'b1;
  assign since_new  = rise ? '0 :
                      ((since_q == pfm_pkg::TickSat) ? since_q : since_q + 1'b1);

  always_comb begin
    last_level_d = last_level_q;
    first_done_d = first_done_q;
    period_d     = period_q;
    since_d      = since_q;
    if (take_i) begin
      last_level_d = level_i;
      since_d      = since_new;
      if (rise) begin
        first_done_d = 1'b1;
        period_d     = '0;
      end else begin
        period_d = period_inc;
      end
    end
  end

  always_comb begin
    item_o.record    = rise & first_done_q;
    item_o.edge_seen = rise;
    item_o.timed_out = since_new > timeout_ticks_i;
    item_o.period    = period_inc;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_level_q <= 1'b0;
      first_done_q <= 1'b0;
      period_q     <= '0;
      since_q      <= '0;
    end else begin
      last_level_q <= last_level_d;
      first_done_q <= first_done_d;
      period_q     <= period_d;
      since_q      <= since_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pfm_fifo.sv -----
`default_nettype none

module pfm_fifo #(
  parameter int unsigned DEPTH = pfm_pkg::QueueDepthDefault
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire pfm_pkg::pfm_item_t push_item_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output pfm_pkg::pfm_item_t      pop_item_o
);

  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(DEPTH + 1);

  pfm_pkg::pfm_item_t mem_q [DEPTH];
  logic [AddrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    count_q, count_d;

  assign full_o     = (count_q == CntW'(DEPTH));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pfm_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle
module pfm_div #(
  parameter int unsigned DVD_W = 35,
  parameter int unsigned DVS_W = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic [DVD_W-1:0] dividend_i,
  input  wire logic [DVS_W-1:0] divisor_i,
  output logic                  done_o,
  output logic [DVD_W-1:0]      quot_o
);

  localparam int unsigned CntW = $clog2(DVD_W + 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DVS_W-1:0] rem_q, rem_d;
  logic [DVS_W-1:0] dvs_q, dvs_d;
  logic [DVS_W:0]   shifted;
  logic [DVS_W:0]   trial;
  logic             qbit;

  assign shifted = {rem_q, dvd_q[DVD_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign qbit    = ~trial[DVS_W];
  assign done_o  = done_q;
  assign quot_o  = dvd_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DVD_W);
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      // remainder stays below the divisor, so it fits DVS_W bits
      rem_d = qbit ? trial[DVS_W-1:0] : shifted[DVS_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], qbit};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/pfm_back.sv -----
`default_nettype none

module pfm_back #(
  parameter int unsigned WINDOW = pfm_pkg::WindowDefault
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [pfm_pkg::TpsW-1:0]  ticks_per_second_i,
  input  wire logic                      item_valid_i,
  input  wire pfm_pkg::pfm_item_t        item_i,
  output logic                           pop_o,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [pfm_pkg::FreqW-1:0]      out_avg_o,
  output logic                           out_edge_o,
  output logic                           out_timeout_o
);

  localparam int unsigned SlotW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SumW   = pfm_pkg::FreqW + SlotW;
  // sum/WINDOW as two chunks of long division, each chunk by reciprocal multiply
  localparam int unsigned ChunkW = (SumW + 1) / 2;
  localparam int unsigned XW     = ChunkW + SlotW;
  localparam int unsigned RcpK   = XW + SlotW;
  localparam int unsigned RcpW   = RcpK + 1;
  localparam int unsigned ProdW  = RcpK + ChunkW;
  localparam longint unsigned RcpVal =
    ((64'd1 << RcpK) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RcpW-1:0] Rcp = RcpW'(RcpVal);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StDivFreq = 3'd1;
  localparam logic [2:0] StAvgHi   = 3'd2;
  localparam logic [2:0] StAvgRem  = 3'd3;
  localparam logic [2:0] StAvgLo   = 3'd4;
  localparam logic [2:0] StOut     = 3'd5;

  logic [2:0]                st_q, st_d;
  logic [pfm_pkg::FreqW-1:0] hist_q [WINDOW];
  logic [SlotW-1:0]          slot_q, slot_d;
  logic [SumW-1:0]           sum_q, sum_d;
  logic [pfm_pkg::FreqW-1:0] avg_q, avg_d;
  logic                      wk_edge_q, wk_edge_d;
  logic                      wk_timeout_q, wk_timeout_d;
  logic                      hist_we;

  logic [ChunkW-1:0]         avg_hi_q, avg_hi_d;
  logic [SlotW-1:0]          rem_q, rem_d;
  logic [XW-1:0]             sum_hi;
  logic [XW-1:0]             avg_x;
  logic [ProdW-1:0]          avg_prod;
  logic [ChunkW-1:0]         avg_part;

  logic                      out_valid_q, out_valid_d;
  logic [pfm_pkg::FreqW-1:0] out_avg_q, out_avg_d;
  logic                      out_edge_q, out_edge_d;
  logic                      out_timeout_q, out_timeout_d;
  logic                      out_free;

  logic                      div_start;
  logic [pfm_pkg::FreqW-1:0] div_dividend;
  logic [pfm_pkg::TickW-1:0] div_divisor;
  logic                      div_done;
  logic [pfm_pkg::FreqW-1:0] div_quot;
  logic [pfm_pkg::FreqW-1:0] freq;
  logic [SumW-1:0]           sum_new;

  assign out_free      = ~out_valid_q | out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign out_avg_o     = out_avg_q;
  assign out_edge_o    = out_edge_q;
  assign out_timeout_o = out_timeout_q;

  assign div_dividend = {ticks_per_second_i, {pfm_pkg::FracW{1'b0}}};
  assign div_divisor  = item_i.period;
  assign freq         = div_quot;
  assign sum_new      = sum_q - SumW'(hist_q[slot_q]) + SumW'(freq);

  // high chunk first, then remainder joined with the low chunk
  assign sum_hi   = XW'(sum_q[SumW-1:ChunkW]);
  assign avg_x    = (st_q == StAvgLo) ? {rem_q, sum_q[ChunkW-1:0]} : sum_hi;
  assign avg_prod = ProdW'(avg_x) * ProdW'(Rcp);
  assign avg_part = avg_prod[ProdW-1:RcpK];

  pfm_div #(
    .DVD_W (pfm_pkg::FreqW),
    .DVS_W (pfm_pkg::TickW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    st_d          = st_q;
    slot_d        = slot_q;
    sum_d         = sum_q;
    avg_d         = avg_q;
    avg_hi_d      = avg_hi_q;
    rem_d         = rem_q;
    wk_edge_d     = wk_edge_q;
    wk_timeout_d  = wk_timeout_q;
    hist_we       = 1'b0;
    pop_o         = 1'b0;
    div_start     = 1'b0;
    out_valid_d   = out_valid_q & ~out_ready_i;
    out_avg_d     = out_avg_q;
    out_edge_d    = out_edge_q;
    out_timeout_d = out_timeout_q;

    unique case (st_q)
      StIdle: begin
        if (item_valid_i) begin
          if (item_i.record) begin
            pop_o        = 1'b1;
            div_start    = 1'b1;
            wk_edge_d    = item_i.edge_seen;
            wk_timeout_d = item_i.timed_out;
            st_d         = StDivFreq;
          end else if (out_free) begin
            pop_o         = 1'b1;
            out_valid_d   = 1'b1;
            out_avg_d     = item_i.timed_out ? '0 : avg_q;
            out_edge_d    = item_i.edge_seen;
            out_timeout_d = item_i.timed_out;
            avg_d         = item_i.timed_out ? '0 : avg_q;
          end
        end
      end
      StDivFreq: begin
        if (div_done) begin
          hist_we = 1'b1;
          sum_d   = sum_new;
          slot_d  = (slot_q == SlotW'(WINDOW - 1)) ? '0 : slot_q + 1'b1;
          st_d    = StAvgHi;
        end
      end
      StAvgHi: begin
        avg_hi_d = avg_part;
        st_d     = StAvgRem;
      end
      StAvgRem: begin
        rem_d = SlotW'(sum_hi - XW'(avg_hi_q) * XW'(WINDOW));
        st_d  = StAvgLo;
      end
      StAvgLo: begin
        avg_d = pfm_pkg::FreqW'({avg_hi_q, avg_part});
        st_d  = StOut;
      end
      StOut: begin
        if (out_free) begin
          out_valid_d   = 1'b1;
          out_avg_d     = wk_timeout_q ? '0 : avg_q;
          out_edge_d    = wk_edge_q;
          out_timeout_d = wk_timeout_q;
          avg_d         = wk_timeout_q ? '0 : avg_q;
          st_d          = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        hist_q[i] <= '0;
      end
    end else if (hist_we) begin
      hist_q[slot_q] <= freq;
    end
  end

  always_ff @(posedge clk_i) begin
    wk_edge_q     <= wk_edge_d;
    wk_timeout_q  <= wk_timeout_d;
    avg_hi_q      <= avg_hi_d;
    rem_q         <= rem_d;
    out_avg_q     <= out_avg_d;
    out_edge_q    <= out_edge_d;
    out_timeout_q <= out_timeout_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= StIdle;
      slot_q      <= '0;
      sum_q       <= '0;
      avg_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      slot_q      <= slot_d;
      sum_q       <= sum_d;
      avg_q       <= avg_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

// ----- sv/period_frequency_meter_avg_unit.sv -----
// Reciprocal frequency meter with a moving average over WINDOW periods.
// s_axis carries one sample of the measured pin per time tick; every
// accepted transfer yields exactly one m_axis transfer, in order.
// m_axis_tdata is the averaged frequency in Q24.8 hertz, m_axis_tuser flags
// a rising edge on that tick and a forced zero after the edge timeout.
// The cfg channel writes ticks_per_second (index 0) and timeout_ticks
// (index 1); other indexes are dropped. cfg_ready_o is always high.
// Ticks without a measured period pass the front, the queue and the output
// register, one per cycle while the back end is idle and m_axis takes them.
// A rising edge after the first one runs the bit-serial divider for
// tps*256/period, then sum/WINDOW as two reciprocal multiplies in states
// StAvgHi, StAvgRem and StAvgLo; the back end takes no other tick until its
// result is in the output register. Ticks keep entering meanwhile until the
// QUEUE_DEPTH-entry queue fills, then s_axis_tready drops.
// Reset clears the history ring, the running sum, the counters and the queue
// and loads the register defaults. A stalled m_axis holds its result; the
// back end stops, the queue fills and the input backs up in turn.
`default_nettype none

module period_frequency_meter_avg_unit #(
  parameter int unsigned WINDOW      = pfm_pkg::WindowDefault,
  parameter int unsigned QUEUE_DEPTH = pfm_pkg::QueueDepthDefault
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [0] pin_level
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [31:0]                        m_axis_tdata,  // [31:0] avg_frequency
  output logic [1:0]                         m_axis_tuser,  // [0] edge_seen, [1] timed_out
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [pfm_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [pfm_pkg::CfgDataW-1:0]  cfg_data_i
);

  logic [pfm_pkg::TpsW-1:0]  tps_q, tps_d;
  logic [pfm_pkg::TickW-1:0] timeout_q, timeout_d;

  logic               take;
  logic               fifo_full;
  logic               fifo_valid;
  logic               fifo_pop;
  pfm_pkg::pfm_item_t front_item;
  pfm_pkg::pfm_item_t fifo_item;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = ~fifo_full;
  assign take          = s_axis_tvalid & ~fifo_full;

  always_comb begin
    tps_d     = tps_q;
    timeout_d = timeout_q;
    if (cfg_valid_i) begin
      if (cfg_index_i == pfm_pkg::CfgTicksPerSecond) begin
        tps_d = cfg_data_i[pfm_pkg::TpsW-1:0];
      end else if (cfg_index_i == pfm_pkg::CfgTimeoutTicks) begin
        timeout_d = cfg_data_i[pfm_pkg::TickW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q     <= pfm_pkg::TpsReset;
      timeout_q <= pfm_pkg::TimeoutReset;
    end else begin
      tps_q     <= tps_d;
      timeout_q <= timeout_d;
    end
  end

  pfm_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (take),
    .level_i         (s_axis_tdata[0]),
    .timeout_ticks_i (timeout_q),
    .item_o          (front_item)
  );

  pfm_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take),
    .push_item_i (front_item),
    .full_o      (fifo_full),
    .pop_i       (fifo_pop),
    .valid_o     (fifo_valid),
    .pop_item_o  (fifo_item)
  );

  pfm_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .ticks_per_second_i (tps_q),
    .item_valid_i       (fifo_valid),
    .item_i             (fifo_item),
    .pop_o              (fifo_pop),
    .out_valid_o        (m_axis_tvalid),
    .out_ready_i        (m_axis_tready),
    .out_avg_o          (m_axis_tdata),
    .out_edge_o         (m_axis_tuser[0]),
    .out_timeout_o      (m_axis_tuser[1])
  );

endmodule

`default_nettype wire

// ----- dv/period_frequency_meter_avg_unit_tb.sv -----
`default_nettype none

module period_frequency_meter_avg_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Win = pfm_pkg::WindowDefault;
  localparam int unsigned PhaseLen = 320;
  localparam logic [pfm_pkg::CfgIdxW-1:0] CfgSpareIdx = 8'd2;
  localparam logic [pfm_pkg::CfgIdxW-1:0] CfgTopIdx   = 8'hFF;
  // high on the first tick, steady high into timeout, early averages,
  // low dropout clearing the average, then a fresh mean; bit 0 goes first
  localparam logic [23:0] FirstSeq = 24'b0100_0000_1010_1010_1011_1111;

  typedef struct packed {
    logic [pfm_pkg::FreqW-1:0] freq;
    logic                      edge_seen;
    logic                      timed_out;
  } meter_result_t;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [7:0]                   s_axis_tdata = '0;   // [0] pin_level
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [31:0]                  m_axis_tdata;        // [31:0] avg_frequency
  logic [1:0]                   m_axis_tuser;        // [0] edge_seen, [1] timed_out
  logic                         cfg_valid_i = 1'b0;
  logic                         cfg_ready_o;
  logic [pfm_pkg::CfgIdxW-1:0]  cfg_index_i = '0;
  logic [pfm_pkg::CfgDataW-1:0] cfg_data_i = '0;

  period_frequency_meter_avg_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // predictor state
  logic [pfm_pkg::TpsW-1:0]  tps_reg     = pfm_pkg::TpsReset;
  logic [pfm_pkg::TickW-1:0] timeout_reg = pfm_pkg::TimeoutReset;
  logic                      prev_level  = 1'b0;
  logic                      armed       = 1'b0;
  logic [pfm_pkg::TickW-1:0] period_cnt  = '0;
  logic [pfm_pkg::TickW-1:0] since_edge  = '0;
  logic [pfm_pkg::FreqW-1:0] ring [Win]  = '{default: '0};
  int unsigned               slot        = 0;
  logic [pfm_pkg::FreqW+3:0] ring_sum    = '0;
  logic [pfm_pkg::FreqW-1:0] avg_q       = '0;

  logic          pin_q [$];
  meter_result_t result_q [$];
  int            mismatches = 0;
  int            idle_in_pct = 0;
  int            stall_pct = 0;
  logic          in_taken = 1'b0;
  logic          hold_ask = 1'b0;
  logic          hold_done = 1'b0;
  int            hold_left = 0;

  function automatic logic [pfm_pkg::TickW-1:0] sat_inc(logic [pfm_pkg::TickW-1:0] v);
    return (v == pfm_pkg::TickSat) ? v : v + 32'd1;
  endfunction

  task automatic meter_tick(input logic level, output meter_result_t r);
    logic                      rise;
    logic [pfm_pkg::TickW-1:0] per;
    logic [pfm_pkg::FreqW-1:0] freq;
    rise = level && !prev_level;
    prev_level = level;
    if (rise) begin
      per = sat_inc(period_cnt);
      if (armed) begin
        freq = {tps_reg, {pfm_pkg::FracW{1'b0}}} / per;
        ring_sum = ring_sum - ring[slot] + freq;
        ring[slot] = freq;
        slot = (slot == Win - 1) ? 0 : slot + 1;
        avg_q = pfm_pkg::FreqW'(ring_sum / Win);
      end
      armed = 1'b1;
      period_cnt = '0;
      since_edge = '0;
    end else begin
      period_cnt = sat_inc(period_cnt);
      since_edge = sat_inc(since_edge);
    end
    r.timed_out = since_edge > timeout_reg;
    if (r.timed_out) avg_q = '0;
    r.freq = avg_q;
    r.edge_seen = rise;
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      if (mismatches < 10) $display("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  // input driver
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (pin_q.size() != 0 && $urandom_range(0, 99) >= idle_in_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, pin_q.pop_front()};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // output backpressure; one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_ask && !hold_done) begin
      hold_left <= 400;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // check output transfers, then predict the accepted input
  always @(posedge clk_i) begin : mon
    meter_result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (result_q.size() == 0) begin
          if (mismatches < 10) $display("output transfer with none pending: %0h", m_axis_tdata);
          mismatches++;
        end else begin
          want = result_q.pop_front();
          check_field("avg_frequency", want.freq, m_axis_tdata);
          check_field("edge_seen", 32'(want.edge_seen), 32'(m_axis_tuser[0]));
          check_field("timed_out", 32'(want.timed_out), 32'(m_axis_tuser[1]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        meter_tick(s_axis_tdata[0], want);
        result_q.push_back(want);
      end
    end
    in_taken <= s_axis_tvalid && s_axis_tready;
  end

  task automatic cfg_write(logic [pfm_pkg::CfgIdxW-1:0] idx,
                           logic [pfm_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      pfm_pkg::CfgTicksPerSecond: tps_reg = data[pfm_pkg::TpsW-1:0];
      pfm_pkg::CfgTimeoutTicks:   timeout_reg = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_idle();
    while (pin_q.size() != 0 || s_axis_tvalid || result_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  // square waves of random period and duty, with noise and long dropouts
  task automatic gen_signal(int count);
    int pushed;
    int kind;
    int per;
    int hi;
    int len;
    logic lvl;
    pushed = 0;
    while (pushed < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 7) begin
        per = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 120) : $urandom_range(2, 12);
        hi = $urandom_range(1, per - 1);
        repeat ($urandom_range(2, 8)) begin
          for (int j = 0; j < per && pushed < count; j++) begin
            pin_q.push_back(j < hi);
            pushed++;
          end
        end
      end else if (kind < 9) begin
        len = $urandom_range(1, 20);
        for (int j = 0; j < len && pushed < count; j++) begin
          pin_q.push_back(1'($urandom_range(0, 1)));
          pushed++;
        end
      end else begin
        len = $urandom_range(1, 80);
        lvl = 1'($urandom_range(0, 1));
        for (int j = 0; j < len && pushed < count; j++) begin
          pin_q.push_back(lvl);
          pushed++;
        end
      end
    end
  endtask

  task automatic run_phase(logic [pfm_pkg::CfgDataW-1:0] tps,
                           logic [pfm_pkg::CfgDataW-1:0] tmo,
                           int in_pct, int out_pct, logic pressure);
    cfg_write(pfm_pkg::CfgTicksPerSecond, tps);
    cfg_write(pfm_pkg::CfgTimeoutTicks, tmo);
    idle_in_pct = in_pct;
    stall_pct = out_pct;
    gen_signal(PhaseLen);
    if (pressure) hold_ask = 1'b1;
    wait_idle();
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    cfg_write(pfm_pkg::CfgTimeoutTicks, 32'd3);
    for (int i = 0; i < 24; i++) pin_q.push_back(FirstSeq[i]);
    wait_idle();

    run_phase({8'd0, pfm_pkg::TpsReset}, pfm_pkg::TimeoutReset, 0, 0, 1'b0);
    cfg_write(CfgSpareIdx, $urandom());
    cfg_write(CfgTopIdx, 32'hFFFF_FFFF);
    run_phase(32'hFFFF_FFFF, 32'd0, 87, 0, 1'b0);
    run_phase(32'd1, 32'd1, 0, 87, 1'b0);
    run_phase(32'd0, 32'hFFFF_FFFF, 18, 18, 1'b0);
    run_phase($urandom_range(1, 16777215), $urandom_range(5, 60), 0, 0, 1'b1);
    run_phase($urandom(), $urandom_range(10, 40), 0, 87, 1'b0);

    repeat (90) @(posedge clk_i);
    if (mismatches == 0 && result_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

`default_nettype wire
